// ===== rtl/stt_pkg.sv =====
`timescale 1ns / 1ps

package stt_pkg;

  // Set-2 scan codes with a fixed meaning.
  localparam logic [7:0] KeyBreak  = 8'hF0;
  localparam logic [7:0] KeyEsc    = 8'h76;
  localparam logic [7:0] KeyLShift = 8'h12;
  localparam logic [7:0] KeyRShift = 8'h59;
  localparam logic [7:0] KeyEnter  = 8'h5A;

  localparam logic [6:0] CharBlank = 7'h20;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic addr_en;
    logic set_break;
    logic clr_break;
    logic set_shift;
    logic clr_shift;
    logic home;
    logic new_line;
    logic advance;
    logic cell_write;
    logic mem_read;
    logic char_capture;
    logic sweep_clr;
    logic sweep_blank;
    logic sweep_step;
    logic out_load;
  } stt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic read_ok;
    logic is_break;
    logic brk_pend;
    logic is_esc;
    logic is_shift;
    logic is_enter;
    logic key_hit;
    logic last_col;
    logic last_row;
    logic sweep_last;
  } stt_stat_t;

  // One keymap entry: hit flag, position in the keymap, plain and shifted character.
  typedef struct packed {
    logic       hit;
    logic [6:0] idx;
    logic [6:0] lo;
    logic [6:0] hi;
  } stt_key_t;

  function automatic stt_key_t stt_key_lookup(input logic [7:0] code);
    stt_key_t k;
    k = '0;
    k.hit = 1'b1;
    case (code)
      8'h16: begin k.idx = 7'd0;  k.lo = 7'h31; k.hi = 7'h21; end
      8'h1e: begin k.idx = 7'd1;  k.lo = 7'h32; k.hi = 7'h22; end
      8'h26: begin k.idx = 7'd2;  k.lo = 7'h33; k.hi = 7'h23; end
      8'h25: begin k.idx = 7'd3;  k.lo = 7'h34; k.hi = 7'h24; end
      8'h2e: begin k.idx = 7'd4;  k.lo = 7'h35; k.hi = 7'h25; end
      8'h36: begin k.idx = 7'd5;  k.lo = 7'h36; k.hi = 7'h26; end
      8'h3d: begin k.idx = 7'd6;  k.lo = 7'h37; k.hi = 7'h27; end
      8'h3e: begin k.idx = 7'd7;  k.lo = 7'h38; k.hi = 7'h28; end
      8'h46: begin k.idx = 7'd8;  k.lo = 7'h39; k.hi = 7'h29; end
      8'h45: begin k.idx = 7'd9;  k.lo = 7'h30; k.hi = 7'h20; end
      8'h4e: begin k.idx = 7'd10; k.lo = 7'h2d; k.hi = 7'h3d; end
      8'h55: begin k.idx = 7'd11; k.lo = 7'h5e; k.hi = 7'h7e; end
      8'h6a: begin k.idx = 7'd12; k.lo = 7'h5c; k.hi = 7'h7c; end
      8'h15: begin k.idx = 7'd13; k.lo = 7'h71; k.hi = 7'h51; end
      8'h1d: begin k.idx = 7'd14; k.lo = 7'h77; k.hi = 7'h57; end
      8'h24: begin k.idx = 7'd15; k.lo = 7'h65; k.hi = 7'h45; end
      8'h2d: begin k.idx = 7'd16; k.lo = 7'h72; k.hi = 7'h52; end
      8'h2c: begin k.idx = 7'd17; k.lo = 7'h74; k.hi = 7'h54; end
      8'h35: begin k.idx = 7'd18; k.lo = 7'h79; k.hi = 7'h59; end
      8'h3c: begin k.idx = 7'd19; k.lo = 7'h75; k.hi = 7'h55; end
      8'h43: begin k.idx = 7'd20; k.lo = 7'h69; k.hi = 7'h49; end
      8'h44: begin k.idx = 7'd21; k.lo = 7'h6f; k.hi = 7'h4f; end
      8'h4d: begin k.idx = 7'd22; k.lo = 7'h70; k.hi = 7'h50; end
      8'h54: begin k.idx = 7'd23; k.lo = 7'h40; k.hi = 7'h60; end
      8'h5b: begin k.idx = 7'd24; k.lo = 7'h5b; k.hi = 7'h7b; end
      8'h1c: begin k.idx = 7'd25; k.lo = 7'h61; k.hi = 7'h41; end
      8'h1b: begin k.idx = 7'd26; k.lo = 7'h73; k.hi = 7'h53; end
      8'h23: begin k.idx = 7'd27; k.lo = 7'h64; k.hi = 7'h44; end
      8'h2b: begin k.idx = 7'd28; k.lo = 7'h66; k.hi = 7'h46; end
      8'h34: begin k.idx = 7'd29; k.lo = 7'h67; k.hi = 7'h47; end
      8'h33: begin k.idx = 7'd30; k.lo = 7'h68; k.hi = 7'h48; end
      8'h3b: begin k.idx = 7'd31; k.lo = 7'h6a; k.hi = 7'h4a; end
      8'h42: begin k.idx = 7'd32; k.lo = 7'h6b; k.hi = 7'h4b; end
      8'h4b: begin k.idx = 7'd33; k.lo = 7'h6c; k.hi = 7'h4c; end
      8'h4c: begin k.idx = 7'd34; k.lo = 7'h3b; k.hi = 7'h2b; end
      8'h52: begin k.idx = 7'd35; k.lo = 7'h3a; k.hi = 7'h2a; end
      8'h5d: begin k.idx = 7'd36; k.lo = 7'h5d; k.hi = 7'h7d; end
      8'h1a: begin k.idx = 7'd37; k.lo = 7'h7a; k.hi = 7'h5a; end
      8'h22: begin k.idx = 7'd38; k.lo = 7'h78; k.hi = 7'h58; end
      8'h21: begin k.idx = 7'd39; k.lo = 7'h63; k.hi = 7'h43; end
      8'h2a: begin k.idx = 7'd40; k.lo = 7'h76; k.hi = 7'h56; end
      8'h32: begin k.idx = 7'd41; k.lo = 7'h62; k.hi = 7'h42; end
      8'h31: begin k.idx = 7'd42; k.lo = 7'h6e; k.hi = 7'h4e; end
      8'h3a: begin k.idx = 7'd43; k.lo = 7'h6d; k.hi = 7'h4d; end
      8'h41: begin k.idx = 7'd44; k.lo = 7'h2c; k.hi = 7'h3c; end
      8'h49: begin k.idx = 7'd45; k.lo = 7'h2e; k.hi = 7'h3e; end
      8'h4a: begin k.idx = 7'd46; k.lo = 7'h2f; k.hi = 7'h3f; end
      8'h51: begin k.idx = 7'd47; k.lo = 7'h5c; k.hi = 7'h5f; end
      8'h29: begin k.idx = 7'd48; k.lo = 7'h20; k.hi = 7'h20; end
      default: k.hit = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/stt_dp.sv =====
`timescale 1ns / 1ps

module stt_dp #(
  parameter int COLUMNS        = 80,
  parameter int ROWS           = 50,
  parameter int KEYMAP_ENTRIES = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stt_pkg::stt_cmd_t  cmd_i,
  output stt_pkg::stt_stat_t stat_o,
  input  logic             action_i,
  input  logic [7:0]       scan_code_i,
  input  logic [5:0]       read_row_i,
  input  logic [6:0]       read_col_i,
  output logic [6:0]       cell_char_o,
  output logic [6:0]       cursor_col_o,
  output logic [5:0]       cursor_row_o,
  output logic             shift_held_o
);
  import stt_pkg::*;

  localparam int Cells = ROWS * COLUMNS;
  localparam int AW    = $clog2(Cells);

  logic          action_q;
  logic [7:0]    code_q;
  logic [5:0]    row_q;
  logic [6:0]    col_q;
  logic [6:0]    x_q;
  logic [5:0]    y_q;
  logic          shift_q;
  logic          brk_q;
  logic [6:0]    char_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] addr_d;
  logic [AW-1:0] idx_q;
  logic          blank_q;
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_blank_q;
  logic [6:0]    rdata_q;
  logic [6:0]    out_char_q;
  logic [6:0]    out_col_q;
  logic [5:0]    out_row_q;
  logic          out_shift_q;

  logic [6:0]    mem_q [Cells];

  stt_key_t      key;
  logic          key_hit;
  logic [6:0]    key_char;
  logic [AW:0]   sweep_raddr;
  logic          sweep_in_range;
  logic          mem_ren;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [6:0]    mem_wdata;

  assign key      = stt_key_lookup(code_q);
  assign key_hit  = key.hit && ({1'b0, key.idx} < 8'(KEYMAP_ENTRIES));
  assign key_char = shift_q ? key.hi : key.lo;

  // During a scrolling sweep the cell one row further down is fetched; a clearing sweep reads nothing.
  assign sweep_raddr    = (AW + 1)'(idx_q) + (AW + 1)'(COLUMNS);
  assign sweep_in_range = sweep_raddr < (AW + 1)'(Cells);

  assign addr_d = action_q ? AW'(row_q) * AW'(COLUMNS) + AW'(col_q)
                           : AW'(y_q) * AW'(COLUMNS) + AW'(x_q);

  assign mem_raddr = cmd_i.sweep_step ? sweep_raddr[AW-1:0] : addr_q;
  assign mem_ren   = cmd_i.mem_read || (cmd_i.sweep_step && !blank_q && sweep_in_range);
  assign mem_we    = wr_pend_q || cmd_i.cell_write;
  assign mem_waddr = wr_pend_q ? wr_addr_q : addr_q;
  assign mem_wdata = wr_pend_q ? (wr_blank_q ? CharBlank : rdata_q) : key_char;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_ren) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q <= action_i;
      code_q   <= scan_code_i;
      row_q    <= read_row_i;
      col_q    <= read_col_i;
    end
    if (cmd_i.addr_en) begin
      addr_q <= addr_d;
    end
    if (cmd_i.load_in) begin
      char_q <= '0;
    end else if (cmd_i.char_capture) begin
      char_q <= rdata_q;
    end
    if (cmd_i.sweep_step) begin
      wr_addr_q  <= idx_q;
      wr_blank_q <= blank_q || !sweep_in_range;
    end
    if (cmd_i.out_load) begin
      out_char_q  <= char_q;
      out_col_q   <= x_q;
      out_row_q   <= y_q;
      out_shift_q <= shift_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      shift_q   <= 1'b0;
      brk_q     <= 1'b0;
      idx_q     <= '0;
      blank_q   <= 1'b1;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.sweep_step;
      if (cmd_i.set_break) begin
        brk_q <= 1'b1;
      end else if (cmd_i.clr_break) begin
        brk_q <= 1'b0;
      end
      if (cmd_i.set_shift) begin
        shift_q <= 1'b1;
      end else if (cmd_i.clr_shift) begin
        shift_q <= 1'b0;
      end
      if (cmd_i.home) begin
        x_q <= '0;
        y_q <= '0;
      end else if (cmd_i.new_line) begin
        x_q <= '0;
        if (!stat_o.last_row) begin
          y_q <= y_q + 6'd1;
        end
      end else if (cmd_i.advance) begin
        x_q <= x_q + 7'd1;
      end
      if (cmd_i.sweep_clr) begin
        idx_q   <= '0;
        blank_q <= cmd_i.sweep_blank;
      end else if (cmd_i.sweep_step) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.action     = action_q;
    stat_o.read_ok    = ({1'b0, row_q} < 7'(ROWS)) && ({1'b0, col_q} < 8'(COLUMNS));
    stat_o.is_break   = code_q == KeyBreak;
    stat_o.brk_pend   = brk_q;
    stat_o.is_esc     = code_q == KeyEsc;
    stat_o.is_shift   = (code_q == KeyLShift) || (code_q == KeyRShift);
    stat_o.is_enter   = code_q == KeyEnter;
    stat_o.key_hit    = key_hit;
    stat_o.last_col   = x_q == 7'(COLUMNS - 1);
    stat_o.last_row   = y_q == 6'(ROWS - 1);
    stat_o.sweep_last = idx_q == AW'(Cells - 1);
  end

  assign cell_char_o  = out_char_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign shift_held_o = out_shift_q;

endmodule

// ===== rtl/stt_ctrl.sv =====
`timescale 1ns / 1ps

module stt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  stt_pkg::stt_stat_t stat_i,
  output stt_pkg::stt_cmd_t  cmd_o
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    StInit,
    StInitDrain,
    StIdle,
    StDecode,
    StRead,
    StCapture,
    StWrite,
    StSweep,
    StDrain,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StInit: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = StInitDrain;
        end
      end
      StInitDrain: state_d = StIdle;
      StIdle: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.load_in = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        cmd_o.addr_en = 1'b1;
        state_d       = StDone;
        if (stat_i.action) begin
          if (stat_i.read_ok) begin
            state_d = StRead;
          end
        end else if (stat_i.is_break) begin
          cmd_o.set_break = 1'b1;
        end else if (stat_i.brk_pend) begin
          cmd_o.clr_break = 1'b1;
          cmd_o.clr_shift = stat_i.is_shift;
        end else if (stat_i.is_esc) begin
          cmd_o.home        = 1'b1;
          cmd_o.sweep_clr   = 1'b1;
          cmd_o.sweep_blank = 1'b1;
          state_d           = StSweep;
        end else if (stat_i.is_shift) begin
          cmd_o.set_shift = 1'b1;
        end else if (stat_i.is_enter) begin
          cmd_o.new_line = 1'b1;
          if (stat_i.last_row) begin
            cmd_o.sweep_clr = 1'b1;
            state_d         = StSweep;
          end
        end else if (stat_i.key_hit) begin
          state_d = StWrite;
        end
      end
      StRead: begin
        cmd_o.mem_read = 1'b1;
        state_d        = StCapture;
      end
      StCapture: begin
        cmd_o.char_capture = 1'b1;
        state_d            = StDone;
      end
      StWrite: begin
        cmd_o.cell_write = 1'b1;
        state_d          = StDone;
        if (stat_i.last_col) begin
          cmd_o.new_line = 1'b1;
          if (stat_i.last_row) begin
            cmd_o.sweep_clr = 1'b1;
            state_d         = StSweep;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      StSweep: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = StDrain;
        end
      end
      StDrain: state_d = StDone;
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StInit;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_q <= state_d == StIdle;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/scancode_text_terminal_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------------
// input    | in_valid_i / in_ready_o | action_i, scan_code_i, read_row_i, read_col_i
// output   | out_valid_o/out_ready_i | cell_char_o, cursor_col_o, cursor_row_o,
//          |                         | shift_held_o
//
// Escape and Enter on the bottom row walk the text store one cell a cycle, and so
// does a typed character that wraps off the bottom row. After reset a clearing pass
// fills the store with spaces. The next item is accepted while a result waits; its own
// result waits for the register.

module scancode_text_terminal_unit #(
  parameter int COLUMNS        = 80,
  parameter int ROWS           = 50,
  parameter int KEYMAP_ENTRIES = 49
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] scan_code_i,
  input  logic [5:0] read_row_i,
  input  logic [6:0] read_col_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] cell_char_o,
  output logic [6:0] cursor_col_o,
  output logic [5:0] cursor_row_o,
  output logic       shift_held_o
);
  import stt_pkg::*;

  stt_cmd_t  cmd;
  stt_stat_t stat;

  // The controller sequences each item and owns both handshakes.
  stt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the text store, cursor, flags and the result register.
  stt_dp #(
    .COLUMNS        (COLUMNS),
    .ROWS           (ROWS),
    .KEYMAP_ENTRIES (KEYMAP_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (action_i),
    .scan_code_i  (scan_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .cell_char_o  (cell_char_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .shift_held_o (shift_held_o)
  );

endmodule

// ===== rtl/stt_checker.sv =====
`timescale 1ns / 1ps

module stt_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 50
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] cell_char_o,
  input logic [6:0] cursor_col_o,
  input logic [5:0] cursor_row_o,
  input logic       shift_held_o
);

  // A result that is not taken stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_char_o)
      && $stable(cursor_col_o) && $stable(cursor_row_o) && $stable(shift_held_o))
    else $error("result changed while stalled");

  // The cursor never leaves the text area.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, cursor_col_o} < 8'(COLUMNS)) && ({1'b0, cursor_row_o} < 7'(ROWS)))
    else $error("cursor outside the text area");

  // One item at a time: an accepted item closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still open after an accepted item");

  // No result can appear in the cycle right after an item enters an empty block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared without work");

endmodule

bind scancode_text_terminal_unit stt_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_stt_checker (.*);
